FILE: rtl/nab_pkg.sv
// Shared types and constants of the 3x3 neighbour-average blur.
package nab_pkg;

	localparam int MAX_WIDTH_DEF      = 1024;
	localparam int MAX_HEIGHT_DEF     = 4096;

	// Configuration register widths and reset values
	localparam int FRAME_WIDTH_W      = 11;
	localparam int FRAME_HEIGHT_W     = 13;
	localparam int CFG_DATA_W         = 13;
	localparam int FRAME_WIDTH_RESET  = 1024;
	localparam int FRAME_HEIGHT_RESET = 768;

	// Register indexes on the configuration port
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// Action codes of an input item
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// Result queue depth
	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// One new window column: from the upper store, the middle store, the stream
	typedef struct packed {
		pixel_t upper;
		pixel_t middle;
		pixel_t lower;
	} column_t;

	typedef struct packed {
		pixel_t pix;
		logic   frame_end;
	} result_t;

endpackage

FILE: rtl/nab_line_store.sv
// Two column-indexed line stores with registered read and write forwarding.
module nab_line_store #(
	parameter int MAX_WIDTH = nab_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [AW-1:0]   rd_addr,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  nab_pkg::pixel_t wr_upper,
	input  nab_pkg::pixel_t wr_middle,
	output nab_pkg::pixel_t rd_upper,
	output nab_pkg::pixel_t rd_middle
);

	nab_pkg::pixel_t upper_mem [MAX_WIDTH];
	nab_pkg::pixel_t middle_mem [MAX_WIDTH];

	nab_pkg::pixel_t upper_rd_q;
	nab_pkg::pixel_t middle_rd_q;
	logic [AW-1:0]   rd_addr_q;

	// Copy of the last write; covers a read issued in the cycle of that write
	logic            fwd_valid_q;
	logic [AW-1:0]   fwd_addr_q;
	nab_pkg::pixel_t fwd_upper_q;
	nab_pkg::pixel_t fwd_middle_q;
	logic            fwd_hit;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr]  <= wr_upper;
			middle_mem[wr_addr] <= wr_middle;
		end
		upper_rd_q  <= upper_mem[rd_addr];
		middle_rd_q <= middle_mem[rd_addr];
		rd_addr_q   <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q   <= wr_addr;
			fwd_upper_q  <= wr_upper;
			fwd_middle_q <= wr_middle;
		end
	end

	assign fwd_hit   = fwd_valid_q && (fwd_addr_q == rd_addr_q);
	assign rd_upper  = fwd_hit ? fwd_upper_q  : upper_rd_q;
	assign rd_middle = fwd_hit ? fwd_middle_q : middle_rd_q;

endmodule

FILE: rtl/nab_window.sv
// 3x3 pixel window with the eight-neighbour average.
module nab_window (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift_en,
	input  nab_pkg::column_t col_in,
	output nab_pkg::pixel_t  centre,
	output nab_pkg::pixel_t  blur
);

	nab_pkg::pixel_t win_q [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (shift_en) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= col_in.upper;
			win_q[1][2] <= col_in.middle;
			win_q[2][2] <= col_in.lower;
		end
	end

	// Each channel floored by eight first, so eight terms stay below 256
	always_comb begin
		logic [7:0] sum_r;
		logic [7:0] sum_g;
		logic [7:0] sum_b;
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (!(r == 1 && c == 1)) begin
					sum_r = sum_r + (win_q[r][c].red   >> 3);
					sum_g = sum_g + (win_q[r][c].green >> 3);
					sum_b = sum_b + (win_q[r][c].blue  >> 3);
				end
			end
		end
		blur.red   = sum_r;
		blur.green = sum_g;
		blur.blue  = sum_b;
	end

	assign centre = win_q[1][1];

endmodule

FILE: rtl/nab_out_fifo.sv
// Small result queue between the window stage and the output channel.
module nab_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  nab_pkg::result_t push_data,
	input  logic             stall,
	output logic             valid,
	output nab_pkg::result_t head,
	output logic [$clog2(nab_pkg::FIFO_DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(nab_pkg::FIFO_DEPTH);
	localparam int CNT_W = $clog2(nab_pkg::FIFO_DEPTH + 1);

	nab_pkg::result_t entry_q [nab_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign valid = (count_q != '0);
	assign pop   = valid && !stall;
	assign head  = entry_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == nab_pkg::FIFO_DEPTH - 1) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == nab_pkg::FIFO_DEPTH - 1) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/neighbour_average_blur_3x3.sv
// Top level: 3x3 neighbour-average blur over a raster RGB pixel stream.
// Throughput: one input transfer per cycle while pixel_stall is low, set by the single read
// and single write per cycle on each line store; pixels and drains may follow back to back.
// Path: a result passes the stage-1 and stage-2 registers before it is pushed into the queue;
// in stream terms results trail the input by one row plus one pixel.
// Reset: stream counters and pending count cleared, width 1024 and height 768 (clamped),
// window cleared; line stores are not cleared and no sweep follows reset.
module neighbour_average_blur_3x3 #(
	parameter int MAX_WIDTH  = nab_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = nab_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_write,
	input  logic                           cfg_index,
	input  logic [nab_pkg::CFG_DATA_W-1:0] cfg_data,
	// pixel channel
	input  logic                           pixel_valid,
	output logic                           pixel_stall,
	input  logic                           action,
	input  logic [7:0]                     red_in,
	input  logic [7:0]                     green_in,
	input  logic [7:0]                     blue_in,
	// result channel
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [7:0]                     red_out,
	output logic [7:0]                     green_out,
	output logic [7:0]                     blue_out,
	output logic                           frame_end
);

	localparam int CW    = $clog2(MAX_WIDTH);      // column counter
	localparam int WW    = $clog2(MAX_WIDTH + 1);  // effective width
	localparam int PW    = $clog2(MAX_WIDTH + 2);  // pending count, up to width + 1
	localparam int RW    = $clog2(MAX_HEIGHT);     // row counter
	localparam int HW    = $clog2(MAX_HEIGHT + 1); // effective height
	localparam int FCW   = $clog2(nab_pkg::FIFO_DEPTH + 1);
	localparam int W_RST = (nab_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
		: nab_pkg::FRAME_WIDTH_RESET;
	localparam int H_RST = (nab_pkg::FRAME_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
		: nab_pkg::FRAME_HEIGHT_RESET;

	// Control carried alongside an item in the memory stage
	typedef struct packed {
		logic is_pixel;
		logic emit;
		logic border;
		logic frame_end;
		logic sel_upper;
	} ctl_t;

	// ------------------------------------------------------------------
	// Configuration, held already clamped to the legal range
	// ------------------------------------------------------------------
	logic [WW-1:0] eff_w_q;
	logic [HW-1:0] eff_h_q;
	logic [31:0]   w_raw;
	logic [31:0]   h_raw;
	logic [WW-1:0] w_new;
	logic [HW-1:0] h_new;

	always_comb begin
		w_raw = 32'(cfg_data[nab_pkg::FRAME_WIDTH_W-1:0]);
		if (w_raw == 32'd0) begin
			w_raw = 32'd1;
		end else if (w_raw > 32'(MAX_WIDTH)) begin
			w_raw = 32'(MAX_WIDTH);
		end
		h_raw = 32'(cfg_data[nab_pkg::FRAME_HEIGHT_W-1:0]);
		if (h_raw == 32'd0) begin
			h_raw = 32'd1;
		end else if (h_raw > 32'(MAX_HEIGHT)) begin
			h_raw = 32'(MAX_HEIGHT);
		end
		w_new = WW'(w_raw);
		h_new = HW'(h_raw);
	end

	// ------------------------------------------------------------------
	// Stream position: decided at transfer time, independent of pixel data
	// ------------------------------------------------------------------
	logic [CW-1:0] in_col_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;
	logic [PW-1:0] pending_q;

	logic [31:0]   w_last;
	logic [31:0]   h_last;
	logic          accept;
	logic          is_drain;
	logic          pend_full;
	logic          emit_s0;
	logic          border_s0;
	logic          fe_s0;
	logic          in_col_wrap;
	logic          out_col_wrap;
	logic          out_row_wrap;
	logic [CW-1:0] rd_addr_s0;

	assign w_last       = 32'(eff_w_q) - 32'd1;
	assign h_last       = 32'(eff_h_q) - 32'd1;
	assign accept       = pixel_valid && !pixel_stall;
	assign is_drain     = (action == nab_pkg::ACT_DRAIN);
	// a full row plus one pixel waiting: the oldest is still in the upper store
	assign pend_full    = 32'(pending_q) >= (32'(eff_w_q) + 32'd1);
	assign emit_s0      = is_drain ? (pending_q != '0) : pend_full;
	assign in_col_wrap  = (32'(in_col_q) == w_last);
	assign out_col_wrap = (32'(out_col_q) == w_last);
	assign out_row_wrap = (32'(out_row_q) == h_last);
	assign border_s0    = (out_row_q == '0) || (out_col_q == '0) || out_row_wrap
		|| out_col_wrap;
	assign fe_s0        = out_row_wrap && out_col_wrap;
	// drains read at the output column, pixels at the input column
	assign rd_addr_s0   = is_drain ? out_col_q : in_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q   <= WW'(W_RST);
			eff_h_q   <= HW'(H_RST);
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				nab_pkg::REG_FRAME_WIDTH: begin
					eff_w_q <= w_new;
				end
				nab_pkg::REG_FRAME_HEIGHT: begin
					eff_h_q <= h_new;
				end
				default: begin
				end
			endcase
			// any register write restarts the stream position
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
		end else if (accept) begin
			if (!is_drain) begin
				in_col_q <= in_col_wrap ? '0 : in_col_q + CW'(1);
				if (!pend_full) begin
					pending_q <= pending_q + PW'(1);
				end
			end else if (emit_s0) begin
				pending_q <= pending_q - PW'(1);
			end
			if (emit_s0) begin
				if (out_col_wrap) begin
					out_col_q <= '0;
					out_row_q <= out_row_wrap ? '0 : out_row_q + RW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: line store data back, read-modify-write, window shift
	// ------------------------------------------------------------------
	logic            valid_s1;
	ctl_t            ctl_s1;
	logic [CW-1:0]   col_s1;
	nab_pkg::pixel_t pix_s1;
	nab_pkg::pixel_t up_rd;
	nab_pkg::pixel_t mid_rd;
	logic            store_wr;
	nab_pkg::column_t win_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			// a drain with nothing pending leaves no trace
			valid_s1 <= accept && (!is_drain || emit_s0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.is_pixel  <= !is_drain;
			ctl_s1.emit      <= emit_s0;
			ctl_s1.border    <= border_s0;
			ctl_s1.frame_end <= fe_s0;
			ctl_s1.sel_upper <= pend_full;
			col_s1           <= rd_addr_s0;
			pix_s1.red       <= red_in;
			pix_s1.green     <= green_in;
			pix_s1.blue      <= blue_in;
		end
	end

	assign store_wr       = valid_s1 && ctl_s1.is_pixel;
	assign win_col.upper  = up_rd;
	assign win_col.middle = mid_rd;
	assign win_col.lower  = pix_s1;

	// middle row moves up, the new pixel takes its place
	nab_line_store #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr_s0),
		.wr_en    (store_wr),
		.wr_addr  (col_s1),
		.wr_upper (mid_rd),
		.wr_middle(pix_s1),
		.rd_upper (up_rd),
		.rd_middle(mid_rd)
	);

	nab_pkg::pixel_t centre;
	nab_pkg::pixel_t blur;

	nab_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift_en(store_wr),
		.col_in  (win_col),
		.centre  (centre),
		.blur    (blur)
	);

	// ------------------------------------------------------------------
	// Stage 2: choose copy or average against the shifted window
	// ------------------------------------------------------------------
	logic             emit_s2;
	logic             drain_s2;
	logic             border_s2;
	logic             frame_end_s2;
	nab_pkg::pixel_t  drain_pix_s2;
	nab_pkg::result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else begin
			emit_s2 <= valid_s1 && ctl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			drain_s2     <= !ctl_s1.is_pixel;
			border_s2    <= ctl_s1.border;
			frame_end_s2 <= ctl_s1.frame_end;
			drain_pix_s2 <= ctl_s1.sel_upper ? up_rd : mid_rd;
		end
	end

	always_comb begin
		if (drain_s2) begin
			res_s2.pix = drain_pix_s2;
		end else if (border_s2) begin
			res_s2.pix = centre;
		end else begin
			res_s2.pix = blur;
		end
		res_s2.frame_end = frame_end_s2;
	end

	// ------------------------------------------------------------------
	// Result queue; the input stalls once queue plus stages could overfill it
	// ------------------------------------------------------------------
	logic             fifo_valid;
	nab_pkg::result_t fifo_head;
	logic [FCW-1:0]   fifo_count;

	nab_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (emit_s2),
		.push_data(res_s2),
		.stall    (result_stall),
		.valid    (fifo_valid),
		.head     (fifo_head),
		.count    (fifo_count)
	);

	assign pixel_stall  = (32'(fifo_count) + 32'(valid_s1) + 32'(emit_s2))
		>= nab_pkg::FIFO_DEPTH;
	assign result_valid = fifo_valid;
	assign red_out      = fifo_head.pix.red;
	assign green_out    = fifo_head.pix.green;
	assign blue_out     = fifo_head.pix.blue;
	assign frame_end    = fifo_head.frame_end;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_fifo_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit_s2 |-> (32'(fifo_count) < nab_pkg::FIFO_DEPTH))
		else $error("result queue pushed while full");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pending_q) <= (32'(eff_w_q) + 32'd1))
		else $error("pending count beyond one row plus one pixel");

	a_out_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(out_col_q) < 32'(eff_w_q)) && (32'(out_row_q) < 32'(eff_h_q)))
		else $error("output position outside the frame");

	a_frame_end_border: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_s2 && !drain_s2 && frame_end_s2) |-> border_s2)
		else $error("last pixel of frame not treated as border");

endmodule
